// ----- rtl/vertex_transform_about_pivot_unit_macros.svh -----
// Assertion macros shared by the vertex transform RTL.
`ifndef VERTEX_TRANSFORM_ABOUT_PIVOT_UNIT_MACROS_SVH
`define VERTEX_TRANSFORM_ABOUT_PIVOT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define VTAP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that an antecedent is followed in the next cycle by a consequent.
`define VTAP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VTAP_ASSERT(lbl, clk, rst, prop, msg)
`define VTAP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/vtap_pkg.sv -----
// Shared types, codes and the quarter-wave sine table for the vertex transform.
package vtap_pkg;

  localparam int MODE_W  = 2;
  localparam int AMT_W   = 16;
  localparam int ANGLE_W = 9;
  localparam int IDX_W   = 3;
  localparam int SINE_W  = 15;
  localparam int SCALE_FRAC = 8;

  localparam logic [MODE_W-1:0] MODE_TRANSLATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SCALE     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ROTATE    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PASS      = 2'd3;

  localparam logic [IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [IDX_W-1:0] REG_AMOUNT_X = 3'd1;
  localparam logic [IDX_W-1:0] REG_AMOUNT_Y = 3'd2;
  localparam logic [IDX_W-1:0] REG_ANGLE    = 3'd3;
  localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd4;
  localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd5;

  localparam logic signed [AMT_W-1:0] UNITY_Q8 = 16'sd256;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [AMT_W-1:0] amount_x;
    logic signed [AMT_W-1:0] amount_y;
    logic [ANGLE_W-1:0]      angle_deg;
  } cfg_t;

  // round(16384 * sin(d)) for d = 0..90 degrees
  localparam logic [SINE_W-1:0] SINE_TAB [0:90] = '{
        15'd0,   15'd286,   15'd572,   15'd857,  15'd1143,  15'd1428,  15'd1713,
     15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
     15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
     15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
     15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
     15'd9397,  15'd9630,  15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  function automatic logic [SINE_W-1:0] sine_q14(input logic [6:0] idx);
    return (idx <= 7'd90) ? SINE_TAB[idx] : '0;
  endfunction

endpackage

// ----- rtl/vertex_transform_about_pivot_unit.sv -----
// Top level of the vertex transform: config registers, trig lookup and datapath.
//
// Transforms one 2-D vertex per beat: translate by signed offsets, scale about a
// pivot with Q8.8 factors (a zero factor on either axis makes both 1.0), or rotate
// counterclockwise about the pivot by a whole-degree angle taken from a quarter-wave
// Q1.14 sine table rescaled to TRIG_FRAC_BITS fraction bits. Products truncate
// toward zero; each result coordinate saturates to COORD_BITS signed bits and
// clipped reports that either axis hit a limit. Mode 3 passes the vertex through.
// Throughput is one vertex per clock while res_stall is low; an accepted input beat
// reaches a valid result through the four register stages (pivot delta, the four
// multipliers, truncating shift, re-center and saturate). Each stage holds its beat
// only when the stage after it is full and held, so bubbles close up under a stalled
// output. Configuration writes are always ready and take effect on the next clock;
// write them only while no vertex is in flight.
module vertex_transform_about_pivot_unit #(
  parameter int COORD_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [vtap_pkg::IDX_W-1:0]   cfg_index,
  input  logic [((COORD_BITS > 16) ? COORD_BITS : 16)-1:0] cfg_data,
  // Vertex input
  input  logic                         vtx_valid,
  output logic                         vtx_stall,
  input  logic signed [COORD_BITS-1:0] x_in,
  input  logic signed [COORD_BITS-1:0] y_in,
  // Result output
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic signed [COORD_BITS-1:0] x_out,
  output logic signed [COORD_BITS-1:0] y_out,
  output logic                         clipped
);

  vtap_pkg::cfg_t                    cfg;
  logic signed [COORD_BITS-1:0]      center_x;
  logic signed [COORD_BITS-1:0]      center_y;
  logic signed [TRIG_FRAC_BITS+1:0]  sin_val;
  logic signed [TRIG_FRAC_BITS+1:0]  cos_val;

  // Hold mode, factors, angle and pivot
  vtap_cfg_regs #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .center_x  (center_x),
    .center_y  (center_y)
  );

  // Sine and cosine follow the angle register; they are stable while vertices flow
  vtap_trig #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig (
    .angle_deg (cfg.angle_deg),
    .sin_val   (sin_val),
    .cos_val   (cos_val)
  );

  // Advance vertices through the four stages
  vtap_pipe #(
    .COORD_BITS     (COORD_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .center_x  (center_x),
    .center_y  (center_y),
    .sin_val   (sin_val),
    .cos_val   (cos_val),
    .vtx_valid (vtx_valid),
    .vtx_stall (vtx_stall),
    .x_in      (x_in),
    .y_in      (y_in),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .x_out     (x_out),
    .y_out     (y_out),
    .clipped   (clipped)
  );

endmodule

// ----- rtl/vtap_trig.sv -----
// Angle reduction, quadrant folding and sine/cosine lookup at the chosen precision.
module vtap_trig #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic [vtap_pkg::ANGLE_W-1:0]  angle_deg,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_val,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_val
);

  localparam int TRIG_W = TRIG_FRAC_BITS + 2;

  logic [vtap_pkg::ANGLE_W-1:0] ang;
  logic [vtap_pkg::ANGLE_W-1:0] ang_c_raw;
  logic [vtap_pkg::ANGLE_W-1:0] ang_c;
  logic [7:0]                   fold_s;
  logic [7:0]                   fold_c;
  logic [vtap_pkg::SINE_W-1:0]  tab_s;
  logic [vtap_pkg::SINE_W-1:0]  tab_c;
  logic [TRIG_W-1:0]            mag_s;
  logic [TRIG_W-1:0]            mag_c;

  // Fold an angle in 0..359 to {negate, table index 0..90}.
  function automatic logic [7:0] fold(input logic [vtap_pkg::ANGLE_W-1:0] a);
    logic [vtap_pkg::ANGLE_W-1:0] idx;
    logic                         neg;
    if (a <= 9'd90) begin
      idx = a;
      neg = 1'b0;
    end else if (a <= 9'd180) begin
      idx = 9'd180 - a;
      neg = 1'b0;
    end else if (a <= 9'd270) begin
      idx = a - 9'd180;
      neg = 1'b1;
    end else begin
      idx = 9'd360 - a;
      neg = 1'b1;
    end
    return {neg, idx[6:0]};
  endfunction

  always_comb begin
    ang       = (angle_deg >= 9'd360) ? angle_deg - 9'd360 : angle_deg;
    ang_c_raw = ang + 9'd90;
    ang_c     = (ang_c_raw >= 9'd360) ? ang_c_raw - 9'd360 : ang_c_raw;
    fold_s    = fold(ang);
    fold_c    = fold(ang_c);
    tab_s     = vtap_pkg::sine_q14(fold_s[6:0]);
    tab_c     = vtap_pkg::sine_q14(fold_c[6:0]);
  end

  generate
    if (TRIG_FRAC_BITS >= 14) begin : g_widen
      assign mag_s = TRIG_W'(tab_s) << (TRIG_FRAC_BITS - 14);
      assign mag_c = TRIG_W'(tab_c) << (TRIG_FRAC_BITS - 14);
    end else begin : g_narrow
      localparam logic [15:0] RND = 16'(1 << (13 - TRIG_FRAC_BITS));
      logic [15:0] rs_s;
      logic [15:0] rs_c;
      assign rs_s  = 16'(tab_s) + RND;
      assign rs_c  = 16'(tab_c) + RND;
      assign mag_s = TRIG_W'(rs_s >> (14 - TRIG_FRAC_BITS));
      assign mag_c = TRIG_W'(rs_c >> (14 - TRIG_FRAC_BITS));
    end
  endgenerate

  assign sin_val = fold_s[7] ? -$signed(mag_s) : $signed(mag_s);
  assign cos_val = fold_c[7] ? -$signed(mag_c) : $signed(mag_c);

endmodule

// ----- rtl/vtap_cfg_regs.sv -----
// Configuration register file written through the index/data port.
module vtap_cfg_regs #(
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vtap_pkg::IDX_W-1:0]        cfg_index,
  input  logic [((COORD_BITS > 16) ? COORD_BITS : 16)-1:0] cfg_data,
  output vtap_pkg::cfg_t                    cfg,
  output logic signed [COORD_BITS-1:0]      center_x,
  output logic signed [COORD_BITS-1:0]      center_y
);

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg      <= '0;
      center_x <= '0;
      center_y <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vtap_pkg::REG_MODE:     cfg.mode      <= cfg_data[vtap_pkg::MODE_W-1:0];
        vtap_pkg::REG_AMOUNT_X: cfg.amount_x  <= $signed(cfg_data[vtap_pkg::AMT_W-1:0]);
        vtap_pkg::REG_AMOUNT_Y: cfg.amount_y  <= $signed(cfg_data[vtap_pkg::AMT_W-1:0]);
        vtap_pkg::REG_ANGLE:    cfg.angle_deg <= cfg_data[vtap_pkg::ANGLE_W-1:0];
        vtap_pkg::REG_CENTER_X: center_x      <= $signed(cfg_data[COORD_BITS-1:0]);
        vtap_pkg::REG_CENTER_Y: center_y      <= $signed(cfg_data[COORD_BITS-1:0]);
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/vtap_pipe.sv -----
// Four-stage transform datapath: offsets, products, truncating shift, re-center and saturate.
`include "vertex_transform_about_pivot_unit_macros.svh"

module vtap_pipe #(
  parameter int COORD_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst,
  input  vtap_pkg::cfg_t                    cfg,
  input  logic signed [COORD_BITS-1:0]      center_x,
  input  logic signed [COORD_BITS-1:0]      center_y,
  input  logic signed [TRIG_FRAC_BITS+1:0]  sin_val,
  input  logic signed [TRIG_FRAC_BITS+1:0]  cos_val,
  input  logic                              vtx_valid,
  output logic                              vtx_stall,
  input  logic signed [COORD_BITS-1:0]      x_in,
  input  logic signed [COORD_BITS-1:0]      y_in,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic signed [COORD_BITS-1:0]      x_out,
  output logic signed [COORD_BITS-1:0]      y_out,
  output logic                              clipped
);

  localparam int TRIG_W = TRIG_FRAC_BITS + 2;
  localparam int DW     = COORD_BITS + 1;                           // pivot-relative delta
  localparam int KW     = (TRIG_W > vtap_pkg::AMT_W) ? TRIG_W : vtap_pkg::AMT_W;
  localparam int TW     = ((DW > vtap_pkg::AMT_W) ? DW : vtap_pkg::AMT_W) + 1;
  localparam int MW     = DW + KW;                                  // one product
  localparam int SW     = MW + 1;                                   // sum of two products
  localparam int RW     = SW + 1;                                   // re-centered result

  localparam logic signed [SW-1:0] TRIG_BIAS  = (SW'(1) << TRIG_FRAC_BITS) - SW'(1);
  localparam logic signed [SW-1:0] SCALE_BIAS = (SW'(1) << vtap_pkg::SCALE_FRAC) - SW'(1);
  localparam logic signed [SW-1:0] SZERO      = '0;
  localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Stage valids and advance enables
  logic v1, v2, v3;
  logic en1, en2, en3, en4;

  // Stage 1
  logic signed [DW-1:0] dx, dy;
  logic signed [KW-1:0] k0, k1, sn;
  logic signed [TW-1:0] tx1, ty1;
  // Stage 2
  logic signed [MW-1:0] m0, m1, m2, m3;
  logic signed [TW-1:0] tx2, ty2;
  // Stage 3
  logic signed [SW-1:0] del_x, del_y;

  // Combinational
  logic                          is_rot, is_scl, is_trn;
  logic                          zero_fac;
  logic signed [vtap_pkg::AMT_W-1:0] fac_x, fac_y;
  logic signed [TW-1:0]          tadd_x, tadd_y;
  logic signed [DW-1:0]          dx_next, dy_next;
  logic signed [SW-1:0]          vx, vy, del_x_next, del_y_next;
  logic signed [RW-1:0]          rx, ry;
  logic                          ovx, unx, ovy, uny;

  function automatic logic signed [SW-1:0] trunc_shift(input logic signed [SW-1:0] v,
                                                       input logic by_trig);
    logic signed [SW-1:0] b;
    logic signed [SW-1:0] t;
    if (by_trig) begin
      b = v[SW-1] ? TRIG_BIAS : SZERO;
      t = (v + b) >>> TRIG_FRAC_BITS;
    end else begin
      b = v[SW-1] ? SCALE_BIAS : SZERO;
      t = (v + b) >>> vtap_pkg::SCALE_FRAC;
    end
    return t;
  endfunction

  assign en4 = !res_valid || !res_stall;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign vtx_stall = !en1;

  always_comb begin
    is_rot   = (cfg.mode == vtap_pkg::MODE_ROTATE);
    is_scl   = (cfg.mode == vtap_pkg::MODE_SCALE);
    is_trn   = (cfg.mode == vtap_pkg::MODE_TRANSLATE);
    zero_fac = (cfg.amount_x == '0) || (cfg.amount_y == '0);
    fac_x    = zero_fac ? vtap_pkg::UNITY_Q8 : cfg.amount_x;
    fac_y    = zero_fac ? vtap_pkg::UNITY_Q8 : cfg.amount_y;
    tadd_x   = is_trn ? TW'(cfg.amount_x) : '0;
    tadd_y   = is_trn ? TW'(cfg.amount_y) : '0;
    dx_next  = DW'(x_in) - DW'(center_x);
    dy_next  = DW'(y_in) - DW'(center_y);
  end

  // Stage 1: pivot-relative delta, multiplier operands, translate sum
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= vtx_valid;
    end
    if (en1) begin
      dx  <= dx_next;
      dy  <= dy_next;
      k0  <= is_rot ? KW'(cos_val) : KW'(fac_x);
      k1  <= is_rot ? KW'(cos_val) : KW'(fac_y);
      sn  <= KW'(sin_val);
      tx1 <= TW'(dx_next) + tadd_x;
      ty1 <= TW'(dy_next) + tadd_y;
    end
  end

  // Stage 2: products
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      m0  <= MW'(dx) * MW'(k0);
      m1  <= MW'(dy) * MW'(k1);
      m2  <= MW'(dy) * MW'(sn);
      m3  <= MW'(dx) * MW'(sn);
      tx2 <= tx1;
      ty2 <= ty1;
    end
  end

  // Stage 3: combine products and truncate toward zero, or take the offset sum
  always_comb begin
    vx = is_rot ? (SW'(m0) - SW'(m2)) : SW'(m0);
    vy = is_rot ? (SW'(m3) + SW'(m1)) : SW'(m1);
    if (is_rot || is_scl) begin
      del_x_next = trunc_shift(vx, is_rot);
      del_y_next = trunc_shift(vy, is_rot);
    end else begin
      del_x_next = SW'(tx2);
      del_y_next = SW'(ty2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      del_x <= del_x_next;
      del_y <= del_y_next;
    end
  end

  // Stage 4: re-center and saturate
  always_comb begin
    rx  = RW'(center_x) + RW'(del_x);
    ry  = RW'(center_y) + RW'(del_y);
    ovx = rx > RW'(CMAX);
    unx = rx < RW'(CMIN);
    ovy = ry > RW'(CMAX);
    uny = ry < RW'(CMIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en4) begin
      res_valid <= v3;
    end
    if (en4) begin
      x_out   <= ovx ? CMAX : (unx ? CMIN : rx[COORD_BITS-1:0]);
      y_out   <= ovy ? CMAX : (uny ? CMIN : ry[COORD_BITS-1:0]);
      clipped <= ovx || unx || ovy || uny;
    end
  end

  `VTAP_ASSERT(a_stall_only_when_full, clk, rst, !vtx_stall || (v1 && v2 && v3 && res_valid && res_stall), "input stalled with room in the pipeline")
  `VTAP_ASSERT_NEXT(a_held_stage_stays, clk, rst, v3 && !en3, v3, "held stage dropped its beat")
  `VTAP_ASSERT(a_clip_at_limit, clk, rst, !(res_valid && clipped) || (x_out == CMAX || x_out == CMIN || y_out == CMAX || y_out == CMIN), "clip flag without a saturated coordinate")

endmodule

// ----- tb/vtap_checker.sv -----
// Scoreboard for the vertex transform: mirrors the registers, predicts each vertex, checks results.
module vtap_checker #(
  parameter int CB = 16,
  parameter int TF = 14,
  parameter int DW = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [vtap_pkg::IDX_W-1:0] cfg_index,
  input  logic [DW-1:0]              cfg_data,
  input  logic                       vtx_valid,
  input  logic                       vtx_stall,
  input  logic signed [CB-1:0]       x_in,
  input  logic signed [CB-1:0]       y_in,
  input  logic                       res_valid,
  input  logic                       res_stall,
  input  logic signed [CB-1:0]       x_out,
  input  logic signed [CB-1:0]       y_out,
  input  logic                       clipped,
  output int                         mismatches,
  output int                         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic                 clipped;
  } vertex_res_t;

  localparam longint ONE_Q8 = 256;

  // round(16384 * sin(d)), d = 0..90
  localparam int SIN_Q14 [0:90] = '{
        0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
     2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
     5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
     8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  logic [vtap_pkg::MODE_W-1:0]       mode_r   = vtap_pkg::MODE_TRANSLATE;
  logic signed [vtap_pkg::AMT_W-1:0] amt_x    = '0;
  logic signed [vtap_pkg::AMT_W-1:0] amt_y    = '0;
  logic [vtap_pkg::ANGLE_W-1:0]      angle_r  = '0;
  logic signed [CB-1:0]              ctr_x    = '0;
  logic signed [CB-1:0]              ctr_y    = '0;
  vertex_res_t                       transformed_q [$];
  int                                results_seen = 0;

  // Table entry rescaled to TF fraction bits.
  function automatic longint trig_at(input int unsigned d);
    longint t;
    t = SIN_Q14[d];
    if (TF >= 14)
      return t <<< (TF - 14);
    return (t + (64'sd1 <<< (13 - TF))) >>> (14 - TF);
  endfunction

  function automatic longint sin_deg(input int unsigned a);
    if (a <= 90)  return trig_at(a);
    if (a <= 180) return trig_at(180 - a);
    if (a <= 270) return -trig_at(a - 180);
    return -trig_at(360 - a);
  endfunction

  function automatic logic signed [CB-1:0] clamp(input longint v, inout bit hit);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (CB - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      v = hi;
    end else if (v < lo) begin
      hit = 1'b1;
      v = lo;
    end
    return v[CB-1:0];
  endfunction

  function automatic vertex_res_t transform_vertex(input logic signed [CB-1:0] x,
                                                   input logic signed [CB-1:0] y);
    longint px, py, cx, cy, ax, ay, rx, ry, s, c, dv;
    int unsigned a;
    bit hit;
    vertex_res_t r;
    px = x;
    py = y;
    cx = ctr_x;
    cy = ctr_y;
    ax = amt_x;
    ay = amt_y;
    dv = 64'sd1 <<< TF;
    hit = 1'b0;
    rx = px;
    ry = py;
    case (mode_r)
      vtap_pkg::MODE_TRANSLATE: begin
        rx = px + ax;
        ry = py + ay;
      end
      vtap_pkg::MODE_SCALE: begin
        // a zero factor on either axis falls back to unity on both
        if (ax == 0 || ay == 0) begin
          ax = ONE_Q8;
          ay = ONE_Q8;
        end
        rx = cx + (ax * (px - cx)) / ONE_Q8;
        ry = cy + (ay * (py - cy)) / ONE_Q8;
      end
      vtap_pkg::MODE_ROTATE: begin
        a  = angle_r % 360;
        s  = sin_deg(a);
        c  = sin_deg((a + 90) % 360);
        rx = cx + ((px - cx) * c - (py - cy) * s) / dv;
        ry = cy + ((px - cx) * s + (py - cy) * c) / dv;
      end
      default: ;
    endcase
    r.x       = clamp(rx, hit);
    r.y       = clamp(ry, hit);
    r.clipped = hit;
    return r;
  endfunction

  always @(posedge clk) begin
    vertex_res_t want;
    if (rst) begin
      transformed_q.delete();
      mode_r       = vtap_pkg::MODE_TRANSLATE;
      amt_x        = '0;
      amt_y        = '0;
      angle_r      = '0;
      ctr_x        = '0;
      ctr_y        = '0;
      results_seen = 0;
      mismatches   = 0;
      outstanding  = 0;
    end else begin
      // Retire before predicting: a result never belongs to a vertex of the same edge.
      if (res_valid && !res_stall) begin
        if (transformed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result %0d with nothing predicted: x %0d y %0d clipped %0b",
                     $realtime, results_seen, x_out, y_out, clipped);
        end else begin
          want = transformed_q.pop_front();
          if (want.x !== x_out || want.y !== y_out || want.clipped !== clipped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] result %0d: x exp %0d got %0d, y exp %0d got %0d, %s%0b got %0b",
                       $realtime, results_seen, want.x, x_out, want.y, y_out,
                       "clipped exp ", want.clipped, clipped);
          end
        end
        results_seen++;
      end
      if (vtx_valid && !vtx_stall)
        transformed_q = {transformed_q, transform_vertex(x_in, y_in)};
      // New register values apply from the next beat on.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vtap_pkg::REG_MODE:     mode_r  = cfg_data[vtap_pkg::MODE_W-1:0];
          vtap_pkg::REG_AMOUNT_X: amt_x   = cfg_data[vtap_pkg::AMT_W-1:0];
          vtap_pkg::REG_AMOUNT_Y: amt_y   = cfg_data[vtap_pkg::AMT_W-1:0];
          vtap_pkg::REG_ANGLE:    angle_r = cfg_data[vtap_pkg::ANGLE_W-1:0];
          vtap_pkg::REG_CENTER_X: ctr_x   = cfg_data[CB-1:0];
          vtap_pkg::REG_CENTER_Y: ctr_y   = cfg_data[CB-1:0];
          default: ;
        endcase
      end
      outstanding = transformed_q.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Top of the vertex transform testbench: clock, reset, stimulus, back-pressure and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB          = 16;
  localparam int TF          = 14;
  localparam int DW          = (CB > 16) ? CB : 16;
  localparam int LATENCY     = 4;
  // A correct run finishes far below this watchdog limit; leave a wide margin.
  localparam int LIMIT       = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int BLOCKS      = 6;
  localparam int BLOCK_ITEMS = 47;

  localparam logic signed [CB-1:0]              C_MIN  = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [CB-1:0]              C_MAX  = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [vtap_pkg::AMT_W-1:0] A_MIN  = 16'sh8000;
  localparam logic signed [vtap_pkg::AMT_W-1:0] A_MAX  = 16'sh7fff;
  localparam logic signed [CB-1:0]              C_ZERO = '0;
  localparam logic signed [vtap_pkg::AMT_W-1:0] A_ZERO = '0;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [vtap_pkg::IDX_W-1:0] cfg_index = '0;
  logic [DW-1:0]              cfg_data  = '0;
  logic                       vtx_valid = 1'b0;
  logic                       vtx_stall;
  logic signed [CB-1:0]       x_in      = '0;
  logic signed [CB-1:0]       y_in      = '0;
  logic                       res_valid;
  logic                       res_stall = 1'b0;
  logic signed [CB-1:0]       x_out;
  logic signed [CB-1:0]       y_out;
  logic                       clipped;

  int mismatches;
  int outstanding;

  // Idle rates in percent per cycle; the receiver rate is read by its own process.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // One long receiver hold-off, armed once from the stimulus.
  logic hold_arm  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  int cycles = 0;

  // Current pivot, so random vertices can cluster around it.
  logic signed [CB-1:0] cur_cx = '0;
  logic signed [CB-1:0] cur_cy = '0;

  vertex_transform_about_pivot_unit #(
    .COORD_BITS    (CB),
    .TRIG_FRAC_BITS(TF)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .vtx_valid(vtx_valid),
    .vtx_stall(vtx_stall),
    .x_in     (x_in),
    .y_in     (y_in),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .x_out    (x_out),
    .y_out    (y_out),
    .clipped  (clipped)
  );

  vtap_checker #(
    .CB(CB),
    .TF(TF),
    .DW(DW)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .vtx_valid  (vtx_valid),
    .vtx_stall  (vtx_stall),
    .x_in       (x_in),
    .y_in       (y_in),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .x_out      (x_out),
    .y_out      (y_out),
    .clipped    (clipped),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always #10 clk = ~clk;

  // Watchdog: give up if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stall, or a long hold-off once armed.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      res_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one vertex beat and hold it until accepted. Called and returns at a rising edge.
  // Stall is sampled at the falling edge, where it is settled for the coming edge.
  task automatic send_vertex(input logic signed [CB-1:0] x, input logic signed [CB-1:0] y);
    bit st;
    while ($urandom_range(99) < send_idle_pct) begin
      vtx_valid <= 1'b0;
      @(posedge clk);
    end
    vtx_valid <= 1'b1;
    x_in      <= x;
    y_in      <= y;
    do begin
      @(negedge clk);
      st = vtx_stall;
      @(posedge clk);
    end while (st);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_empty();
    bit done;
    vtx_valid <= 1'b0;
    do begin
      @(negedge clk);
      done = (outstanding == 0);
      @(posedge clk);
    end while (!done);
  endtask

  // Drain, then write all six registers in turn.
  task automatic apply_cfg(input logic [vtap_pkg::MODE_W-1:0]       m,
                           input logic signed [vtap_pkg::AMT_W-1:0] ax,
                           input logic signed [vtap_pkg::AMT_W-1:0] ay,
                           input logic [vtap_pkg::ANGLE_W-1:0]      ang,
                           input logic signed [CB-1:0]              cx,
                           input logic signed [CB-1:0]              cy);
    logic [vtap_pkg::IDX_W-1:0] idx [6];
    logic [DW-1:0]              val [6];
    bit                         rdy;
    wait_empty();
    idx = '{vtap_pkg::REG_MODE, vtap_pkg::REG_AMOUNT_X, vtap_pkg::REG_AMOUNT_Y,
            vtap_pkg::REG_ANGLE, vtap_pkg::REG_CENTER_X, vtap_pkg::REG_CENTER_Y};
    val[0] = DW'(m);
    val[1] = DW'(ax);
    val[2] = DW'(ay);
    val[3] = DW'(ang);
    val[4] = DW'(cx);
    val[5] = DW'(cy);
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do begin
        @(negedge clk);
        rdy = cfg_ready;
        @(posedge clk);
      end while (!rdy);
    end
    cfg_valid <= 1'b0;
    cur_cx = cx;
    cur_cy = cy;
  endtask

  // Extremes, near the pivot, or anywhere in range.
  function automatic logic signed [CB-1:0] pick_coord(input logic signed [CB-1:0] ctr);
    logic [31:0] r;
    int          offs;
    r    = $urandom;
    offs = int'($urandom_range(400)) - 200;
    case ($urandom_range(9))
      0:          return C_MIN;
      1:          return C_MAX;
      2, 3, 4, 5: return r[CB-1:0];
      default:    return ctr + offs[CB-1:0];
    endcase
  endfunction

  function automatic logic signed [vtap_pkg::AMT_W-1:0] pick_amount();
    logic [31:0] r;
    int          offs;
    r    = $urandom;
    offs = int'($urandom_range(1023)) - 512;
    case ($urandom_range(9))
      0:       return A_MIN;
      1:       return A_MAX;
      2:       return A_ZERO;
      3:       return vtap_pkg::UNITY_Q8;
      4:       return -vtap_pkg::UNITY_Q8;
      5, 6:    return offs[vtap_pkg::AMT_W-1:0];
      default: return r[vtap_pkg::AMT_W-1:0];
    endcase
  endfunction

  // Random setting; angles past a full turn show up now and then.
  task automatic rand_cfg();
    logic [vtap_pkg::MODE_W-1:0]  m;
    logic [vtap_pkg::ANGLE_W-1:0] ang;
    case ($urandom_range(9))
      0, 1, 2: m = vtap_pkg::MODE_TRANSLATE;
      3, 4, 5: m = vtap_pkg::MODE_SCALE;
      6, 7, 8: m = vtap_pkg::MODE_ROTATE;
      default: m = vtap_pkg::MODE_PASS;
    endcase
    if ($urandom_range(4) == 0)
      ang = vtap_pkg::ANGLE_W'($urandom_range(511, 360));
    else
      ang = vtap_pkg::ANGLE_W'($urandom_range(359));
    apply_cfg(m, pick_amount(), pick_amount(), ang, pick_coord(C_ZERO), pick_coord(C_ZERO));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part runs with the sender mostly busy and the receiver mostly stalled.
    send_idle_pct = 20;
    recv_idle_pct <= 88;

    // Reset values: translate by zero.
    send_vertex(C_ZERO, C_ZERO);
    send_vertex(C_MAX, C_MIN);
    send_vertex(C_MIN, C_MAX);

    // Translate at the offset extremes: both axes clip, then no clip.
    apply_cfg(vtap_pkg::MODE_TRANSLATE, A_MAX, A_MIN, 9'd0, C_ZERO, C_ZERO);
    send_vertex(C_MAX, C_MIN);
    send_vertex(C_MIN, C_MAX);
    apply_cfg(vtap_pkg::MODE_TRANSLATE, A_MIN, A_MAX, 9'd359, C_MAX, C_MIN);
    send_vertex(-16'sd1, 16'sd1);
    send_vertex(C_ZERO, C_ZERO);

    // Zero factor on either axis forces unity on both.
    apply_cfg(vtap_pkg::MODE_SCALE, A_ZERO, 16'sd512, 9'd0, 16'sd100, -16'sd100);
    send_vertex(16'sd1000, -16'sd1000);
    apply_cfg(vtap_pkg::MODE_SCALE, 16'sd512, A_ZERO, 9'd0, 16'sd100, -16'sd100);
    send_vertex(16'sd1000, -16'sd1000);

    // Negative factor mirrors about the pivot; large factors saturate.
    apply_cfg(vtap_pkg::MODE_SCALE, -16'sd256, A_MAX, 9'd0, 16'sd100, -16'sd100);
    send_vertex(16'sd300, -16'sd99);
    send_vertex(C_MIN, C_MAX);
    apply_cfg(vtap_pkg::MODE_SCALE, A_MIN, A_MIN, 9'd0, C_MIN, C_MAX);
    send_vertex(C_MAX, C_MIN);
    send_vertex(-16'sd32767, 16'sd32766);

    // Tiny negative factor: truncation toward zero, not floor.
    apply_cfg(vtap_pkg::MODE_SCALE, -16'sd1, 16'sd1, 9'd0, C_ZERO, C_ZERO);
    send_vertex(16'sd300, -16'sd300);

    // Rotation at the quadrant boundaries and in between.
    apply_cfg(vtap_pkg::MODE_ROTATE, A_ZERO, A_ZERO, 9'd0, C_ZERO, C_ZERO);
    send_vertex(16'sd12345, -16'sd321);
    apply_cfg(vtap_pkg::MODE_ROTATE, A_ZERO, A_ZERO, 9'd90, C_ZERO, C_ZERO);
    send_vertex(C_MAX, C_MIN);
    apply_cfg(vtap_pkg::MODE_ROTATE, A_ZERO, A_ZERO, 9'd180, C_MIN, C_MIN);
    send_vertex(C_MAX, C_MAX);
    apply_cfg(vtap_pkg::MODE_ROTATE, A_ZERO, A_ZERO, 9'd270, 16'sd10, 16'sd20);
    send_vertex(16'sd1000, -16'sd500);
    apply_cfg(vtap_pkg::MODE_ROTATE, A_ZERO, A_ZERO, 9'd45, 16'sd10, 16'sd20);
    send_vertex(C_MAX, C_MAX);

    // Angles of a full turn or more wrap around.
    apply_cfg(vtap_pkg::MODE_ROTATE, A_MAX, A_MIN, 9'd360, 16'sd10, 16'sd20);
    send_vertex(16'sd700, 16'sd300);
    apply_cfg(vtap_pkg::MODE_ROTATE, A_MAX, A_MIN, 9'd511, 16'sd10, 16'sd20);
    send_vertex(16'sd700, 16'sd300);

    // Unused mode passes the vertex through.
    apply_cfg(vtap_pkg::MODE_PASS, A_MAX, A_MIN, 9'd90, 16'sd5, 16'sd5);
    send_vertex(C_MIN, C_MAX);
    send_vertex(16'sd5, -16'sd5);

    // Random part: three idle profiles, each with a handful of settings.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct <= 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct <= 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int blk = 0; blk < BLOCKS; blk++) begin
        rand_cfg();
        // Hold the result side off while the sender keeps offering, to fill the pipe.
        if (phase == 2 && blk == 0)
          hold_arm <= 1'b1;
        for (int n = 0; n < BLOCK_ITEMS; n++)
          send_vertex(pick_coord(cur_cx), pick_coord(cur_cy));
      end
    end

    // Drain, then wait for any stray results to show up.
    wait_empty();
    repeat (2 * LATENCY) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/vtap_pkg.sv
rtl/vtap_trig.sv
rtl/vtap_cfg_regs.sv
rtl/vtap_pipe.sv
rtl/vertex_transform_about_pivot_unit.sv
tb/vtap_checker.sv
tb/tb_top.sv
